@@ hw/rtl/keo_pkg.sv @@
package keo_pkg;

   localparam int WORD_WIDTH = 32;
   // Saturation width follows the word width, held between 24 and 32 bits.
   localparam int WORD_BITS = (WORD_WIDTH < 24) ? 24 : ((WORD_WIDTH > 32) ? 32 : WORD_WIDTH);
   localparam logic signed [63:0] WORD_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WORD_MIN = -WORD_MAX - 64'sd1;

   localparam logic signed [33:0] PI_Q428 = 34'sd843314857;
   localparam logic signed [33:0] TWO_PI_Q428 = 34'sd1686629713;
   localparam logic [63:0] G_CAP = 64'h0000_0000_7FFF_FFFF;

   localparam logic [30:0] GRAV_RESET = 31'd65536;
   localparam logic [15:0] STEP_RESET = 16'd655;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAV = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP = 2'd1;

   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam logic [6:0] MUL_STEPS = 7'd32;
   localparam logic [6:0] DIV_STEPS = 7'd64;
   localparam logic [6:0] SQRT_STEPS = 7'd32;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] opa;
      logic [63:0] opb;
   } keo_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } keo_sts_type;

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      abs32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [63:0] signed_mag(input logic [63:0] m, input logic neg);
      signed_mag = neg ? -$signed(m) : $signed(m);
   endfunction

   // Returns the saturation flag above the clamped word.
   function automatic logic [32:0] sat_word(input logic signed [63:0] v);
      if (v > WORD_MAX) begin
         sat_word = {1'b1, WORD_MAX[31:0]};
      end else if (v < WORD_MIN) begin
         sat_word = {1'b1, WORD_MIN[31:0]};
      end else begin
         sat_word = {1'b0, v[31:0]};
      end
   endfunction

endpackage

@@ hw/rtl/keo_if.sv @@
interface keo_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] load_pos_x;
   logic signed [31:0] load_pos_y;
   logic signed [31:0] load_vel_x;
   logic signed [31:0] load_vel_y;
   logic signed [30:0] load_heading;
   logic signed [31:0] load_spin;

   modport source (output valid, kind, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                   load_heading, load_spin, input ready);
   modport sink (input valid, kind, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                 load_heading, load_spin, output ready);
endinterface

interface keo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [30:0] heading;
   logic signed [31:0] ang_momentum;
   logic signed [31:0] lrl_x;
   logic signed [31:0] lrl_y;
   logic               zero_radius;
   logic               saturated;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, heading, ang_momentum, lrl_x,
                   lrl_y, zero_radius, saturated, input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, heading, ang_momentum, lrl_x,
                 lrl_y, zero_radius, saturated, output ready);
endinterface

@@ hw/rtl/keo_serial_unit.sv @@
module keo_serial_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  keo_pkg::keo_cmd_type cmd,
   output keo_pkg::keo_sts_type sts
);

   logic [63:0] acc_ff;
   logic [63:0] rem_ff;
   logic [63:0] opnd_ff;
   logic [31:0] root_ff;
   logic [1:0]  op_ff;
   logic [6:0]  cnt_ff;
   logic        run_ff;

   logic [32:0] mul_sum;
   logic [64:0] div_trial;
   logic        div_ge;
   logic [63:0] sq_trial;
   logic [63:0] sq_root_trial;
   logic        sq_ge;

   // Shift-add multiply: one multiplier bit per cycle.
   assign mul_sum = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, opnd_ff[31:0]} : 33'd0);
   // Restoring division: one quotient bit per cycle.
   assign div_trial = {rem_ff, acc_ff[63]};
   assign div_ge = div_trial >= {1'b0, opnd_ff};
   // Digit-by-digit square root: two radicand bits, one root bit per cycle.
   assign sq_trial = {rem_ff[61:0], acc_ff[63:62]};
   assign sq_root_trial = {30'd0, root_ff, 2'b01};
   assign sq_ge = sq_trial >= sq_root_trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (cmd.start) begin
         run_ff <= 1'b1;
         op_ff <= cmd.op;
         rem_ff <= '0;
         root_ff <= '0;
         case (cmd.op)
            keo_pkg::OP_MUL: begin
               acc_ff <= {32'd0, cmd.opb[31:0]};
               opnd_ff <= cmd.opa;
               cnt_ff <= keo_pkg::MUL_STEPS;
            end
            keo_pkg::OP_DIV: begin
               acc_ff <= cmd.opa;
               opnd_ff <= cmd.opb;
               cnt_ff <= keo_pkg::DIV_STEPS;
            end
            default: begin
               acc_ff <= cmd.opa;
               opnd_ff <= cmd.opb;
               cnt_ff <= keo_pkg::SQRT_STEPS;
            end
         endcase
      end else if (run_ff) begin
         if (cnt_ff == 7'd0) begin
            run_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 7'd1;
            case (op_ff)
               keo_pkg::OP_MUL: begin
                  acc_ff <= {mul_sum, acc_ff[31:1]};
               end
               keo_pkg::OP_DIV: begin
                  rem_ff <= div_ge ? 64'(div_trial - {1'b0, opnd_ff}) : div_trial[63:0];
                  acc_ff <= {acc_ff[62:0], div_ge};
               end
               default: begin
                  rem_ff <= sq_ge ? (sq_trial - sq_root_trial) : sq_trial;
                  root_ff <= {root_ff[30:0], sq_ge};
                  acc_ff <= {acc_ff[61:0], 2'b00};
               end
            endcase
         end
      end
   end

   assign sts.done = run_ff && (cnt_ff == 7'd0);
   assign sts.result = (op_ff == keo_pkg::OP_SQRT) ? {32'd0, root_ff} : acc_ff;

endmodule

@@ hw/rtl/kepler_orbit_euler_step.sv @@
// Channel  Dir  Handshake          Payload
// req_if   in   valid / ready      kind, load state fields
// rsp_if   out  valid / ready      new state, r x v, Runge-Lenz vector, flags
// csr_*    in   csr_we, no wait    csr_index, csr_wdata
//
// One shared serial unit does every multiply, square root and divide.
// The input is taken only in the idle state; a finished result waits in the
// output register while the next item is taken and worked on.
// Reset is synchronous and clears the orbit state and loads the register defaults.
module kepler_orbit_euler_step (
   input  logic                                clock,
   input  logic                                reset,
   keo_req_if.sink                             req_if,
   keo_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [keo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [30:0]                         csr_wdata
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_WRAP = 5'd1;
   localparam logic [4:0] S_SQX  = 5'd2;
   localparam logic [4:0] S_SQY  = 5'd3;
   localparam logic [4:0] S_SQRT = 5'd4;
   localparam logic [4:0] S_UX   = 5'd5;
   localparam logic [4:0] S_UY   = 5'd6;
   localparam logic [4:0] S_G    = 5'd7;
   localparam logic [4:0] S_AX   = 5'd8;
   localparam logic [4:0] S_AY   = 5'd9;
   localparam logic [4:0] S_PX   = 5'd10;
   localparam logic [4:0] S_PY   = 5'd11;
   localparam logic [4:0] S_VX   = 5'd12;
   localparam logic [4:0] S_VY   = 5'd13;
   localparam logic [4:0] S_HD   = 5'd14;
   localparam logic [4:0] S_ANA  = 5'd15;
   localparam logic [4:0] S_ANB  = 5'd16;
   localparam logic [4:0] S_GX   = 5'd17;
   localparam logic [4:0] S_GY   = 5'd18;
   localparam logic [4:0] S_LX   = 5'd19;
   localparam logic [4:0] S_LY   = 5'd20;
   localparam logic [4:0] S_OUT  = 5'd21;

   logic [4:0]         state_ff;
   logic               busy_ff;
   logic               emit_ff;
   logic               zero_ff;
   logic               sat_ff;
   logic signed [31:0] pos_x_ff;
   logic signed [31:0] pos_y_ff;
   logic signed [31:0] vel_x_ff;
   logic signed [31:0] vel_y_ff;
   logic signed [31:0] head_ff;
   logic signed [31:0] spin_ff;
   logic [30:0]        gm_ff;
   logic [15:0]        dt_ff;
   logic signed [33:0] hw_ff;
   logic [63:0]        sq_ff;
   logic [31:0]        rad_ff;
   logic [30:0]        ux_ff;
   logic [30:0]        uy_ff;
   logic [30:0]        g_ff;
   logic signed [31:0] acc_x_ff;
   logic signed [31:0] acc_y_ff;
   logic signed [63:0] t_ff;
   logic signed [31:0] ang_ff;
   logic signed [31:0] gx_ff;
   logic signed [31:0] gy_ff;
   logic signed [31:0] lx_ff;
   logic signed [31:0] ly_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] o_pos_x_ff;
   logic signed [31:0] o_pos_y_ff;
   logic signed [31:0] o_vel_x_ff;
   logic signed [31:0] o_vel_y_ff;
   logic signed [30:0] o_head_ff;
   logic signed [31:0] o_ang_ff;
   logic signed [31:0] o_lx_ff;
   logic signed [31:0] o_ly_ff;
   logic               o_zero_ff;
   logic               o_sat_ff;

   keo_pkg::keo_cmd_type unit_cmd;
   keo_pkg::keo_sts_type unit_sts;

   logic [31:0]        mx, my, mvx, mvy, mspin, mang, macx, macy;
   logic [63:0]        res, p16, p30, sq_sum;
   logic               compute;
   logic signed [63:0] d_px, d_py, d_vx, d_vy, d_hd, t_b, t_lx, t_ly;
   logic [32:0]        sw_px, sw_py, sw_vx, sw_vy, sw_ang, sw_lx, sw_ly;
   logic [32:0]        sw_lpx, sw_lpy, sw_lvx, sw_lvy;
   logic signed [63:0] m_ax, m_ay, m_gx, m_gy;

   keo_serial_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .sts   (unit_sts)
   );

   assign mx = keo_pkg::abs32(pos_x_ff);
   assign my = keo_pkg::abs32(pos_y_ff);
   assign mvx = keo_pkg::abs32(vel_x_ff);
   assign mvy = keo_pkg::abs32(vel_y_ff);
   assign mspin = keo_pkg::abs32(spin_ff);
   assign mang = keo_pkg::abs32(ang_ff);
   assign macx = keo_pkg::abs32(acc_x_ff);
   assign macy = keo_pkg::abs32(acc_y_ff);

   assign res = unit_sts.result;
   assign p16 = res >> 16;
   assign p30 = res >> 30;
   assign sq_sum = sq_ff + res;

   assign d_px = keo_pkg::signed_mag(p16, vel_x_ff[31]);
   assign d_py = keo_pkg::signed_mag(p16, vel_y_ff[31]);
   assign d_vx = keo_pkg::signed_mag(p16, acc_x_ff[31]);
   assign d_vy = keo_pkg::signed_mag(p16, acc_y_ff[31]);
   assign d_hd = keo_pkg::signed_mag(p16, spin_ff[31]);
   assign t_b = keo_pkg::signed_mag(p16, pos_y_ff[31] ^ vel_x_ff[31]);
   assign t_lx = keo_pkg::signed_mag(p16, vel_y_ff[31] ^ ang_ff[31]);
   assign t_ly = keo_pkg::signed_mag(p16, vel_x_ff[31] ^ ang_ff[31]);
   // The pull points toward the center, against the position's sign.
   assign m_ax = keo_pkg::signed_mag(p30, !pos_x_ff[31]);
   assign m_ay = keo_pkg::signed_mag(p30, !pos_y_ff[31]);
   assign m_gx = keo_pkg::signed_mag(p30, pos_x_ff[31]);
   assign m_gy = keo_pkg::signed_mag(p30, pos_y_ff[31]);

   assign sw_px = keo_pkg::sat_word(64'(pos_x_ff) + d_px);
   assign sw_py = keo_pkg::sat_word(64'(pos_y_ff) + d_py);
   assign sw_vx = keo_pkg::sat_word(64'(vel_x_ff) + d_vx);
   assign sw_vy = keo_pkg::sat_word(64'(vel_y_ff) + d_vy);
   assign sw_ang = keo_pkg::sat_word(t_ff - t_b);
   assign sw_lx = keo_pkg::sat_word(t_lx - 64'(gx_ff));
   assign sw_ly = keo_pkg::sat_word(-t_ly - 64'(gy_ff));
   assign sw_lpx = keo_pkg::sat_word(64'(req_if.load_pos_x));
   assign sw_lpy = keo_pkg::sat_word(64'(req_if.load_pos_y));
   assign sw_lvx = keo_pkg::sat_word(64'(req_if.load_vel_x));
   assign sw_lvy = keo_pkg::sat_word(64'(req_if.load_vel_y));

   assign compute = !(state_ff inside {S_IDLE, S_WRAP, S_OUT});

   always_comb begin
      unit_cmd.start = compute && !busy_ff;
      unit_cmd.op = keo_pkg::OP_MUL;
      unit_cmd.opa = '0;
      unit_cmd.opb = '0;
      case (state_ff)
         S_SQX: begin
            unit_cmd.opa = {32'd0, mx};
            unit_cmd.opb = {32'd0, mx};
         end
         S_SQY: begin
            unit_cmd.opa = {32'd0, my};
            unit_cmd.opb = {32'd0, my};
         end
         S_SQRT: begin
            unit_cmd.op = keo_pkg::OP_SQRT;
            unit_cmd.opa = sq_ff;
         end
         S_UX: begin
            unit_cmd.op = keo_pkg::OP_DIV;
            unit_cmd.opa = {2'd0, mx, 30'd0};
            unit_cmd.opb = {32'd0, rad_ff};
         end
         S_UY: begin
            unit_cmd.op = keo_pkg::OP_DIV;
            unit_cmd.opa = {2'd0, my, 30'd0};
            unit_cmd.opb = {32'd0, rad_ff};
         end
         S_G: begin
            unit_cmd.op = keo_pkg::OP_DIV;
            unit_cmd.opa = {17'd0, gm_ff, 16'd0};
            unit_cmd.opb = sq_ff;
         end
         S_AX: begin
            unit_cmd.opa = {33'd0, g_ff};
            unit_cmd.opb = {33'd0, ux_ff};
         end
         S_AY: begin
            unit_cmd.opa = {33'd0, g_ff};
            unit_cmd.opb = {33'd0, uy_ff};
         end
         S_PX: begin
            unit_cmd.opa = {32'd0, mvx};
            unit_cmd.opb = {48'd0, dt_ff};
         end
         S_PY: begin
            unit_cmd.opa = {32'd0, mvy};
            unit_cmd.opb = {48'd0, dt_ff};
         end
         S_VX: begin
            unit_cmd.opa = {32'd0, macx};
            unit_cmd.opb = {48'd0, dt_ff};
         end
         S_VY: begin
            unit_cmd.opa = {32'd0, macy};
            unit_cmd.opb = {48'd0, dt_ff};
         end
         S_HD: begin
            unit_cmd.opa = {32'd0, mspin};
            unit_cmd.opb = {48'd0, dt_ff};
         end
         S_ANA: begin
            unit_cmd.opa = {32'd0, mx};
            unit_cmd.opb = {32'd0, mvy};
         end
         S_ANB: begin
            unit_cmd.opa = {32'd0, my};
            unit_cmd.opb = {32'd0, mvx};
         end
         S_GX: begin
            unit_cmd.opa = {33'd0, gm_ff};
            unit_cmd.opb = {33'd0, ux_ff};
         end
         S_GY: begin
            unit_cmd.opa = {33'd0, gm_ff};
            unit_cmd.opb = {33'd0, uy_ff};
         end
         S_LX: begin
            unit_cmd.opa = {32'd0, mvy};
            unit_cmd.opb = {32'd0, mang};
         end
         S_LY: begin
            unit_cmd.opa = {32'd0, mvx};
            unit_cmd.opb = {32'd0, mang};
         end
         default: begin
            unit_cmd.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         emit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         head_ff <= '0;
         spin_ff <= '0;
         gm_ff <= keo_pkg::GRAV_RESET;
         dt_ff <= keo_pkg::STEP_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               keo_pkg::CSR_GRAV: gm_ff <= csr_wdata;
               keo_pkg::CSR_STEP: dt_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (compute) begin
            if (!busy_ff) begin
               busy_ff <= 1'b1;
            end else if (unit_sts.done) begin
               busy_ff <= 1'b0;
               case (state_ff)
                  S_SQX: begin
                     sq_ff <= res;
                     state_ff <= S_SQY;
                  end
                  S_SQY: begin
                     sq_ff <= sq_sum;
                     if (sq_sum == 64'd0) begin
                        // No direction at the center: the radial terms drop out.
                        zero_ff <= 1'b1;
                        acc_x_ff <= '0;
                        acc_y_ff <= '0;
                        gx_ff <= '0;
                        gy_ff <= '0;
                        state_ff <= emit_ff ? S_LX : S_PX;
                     end else begin
                        state_ff <= S_SQRT;
                     end
                  end
                  S_SQRT: begin
                     rad_ff <= res[31:0];
                     state_ff <= S_UX;
                  end
                  S_UX: begin
                     ux_ff <= res[30:0];
                     state_ff <= S_UY;
                  end
                  S_UY: begin
                     uy_ff <= res[30:0];
                     state_ff <= emit_ff ? S_GX : S_G;
                  end
                  S_G: begin
                     if (res > keo_pkg::G_CAP) begin
                        g_ff <= keo_pkg::G_CAP[30:0];
                        sat_ff <= 1'b1;
                     end else begin
                        g_ff <= res[30:0];
                     end
                     state_ff <= S_AX;
                  end
                  S_AX: begin
                     acc_x_ff <= m_ax[31:0];
                     state_ff <= S_AY;
                  end
                  S_AY: begin
                     acc_y_ff <= m_ay[31:0];
                     state_ff <= S_PX;
                  end
                  S_PX: begin
                     pos_x_ff <= sw_px[31:0];
                     sat_ff <= sat_ff | sw_px[32];
                     state_ff <= S_PY;
                  end
                  S_PY: begin
                     pos_y_ff <= sw_py[31:0];
                     sat_ff <= sat_ff | sw_py[32];
                     state_ff <= S_VX;
                  end
                  S_VX: begin
                     vel_x_ff <= sw_vx[31:0];
                     sat_ff <= sat_ff | sw_vx[32];
                     state_ff <= S_VY;
                  end
                  S_VY: begin
                     vel_y_ff <= sw_vy[31:0];
                     sat_ff <= sat_ff | sw_vy[32];
                     state_ff <= S_HD;
                  end
                  S_HD: begin
                     hw_ff <= 34'(head_ff) + $signed(d_hd[33:0]);
                     state_ff <= S_WRAP;
                  end
                  S_ANA: begin
                     t_ff <= keo_pkg::signed_mag(p16, pos_x_ff[31] ^ vel_y_ff[31]);
                     state_ff <= S_ANB;
                  end
                  S_ANB: begin
                     ang_ff <= sw_ang[31:0];
                     sat_ff <= sat_ff | sw_ang[32];
                     state_ff <= S_SQX;
                  end
                  S_GX: begin
                     gx_ff <= m_gx[31:0];
                     state_ff <= S_GY;
                  end
                  S_GY: begin
                     gy_ff <= m_gy[31:0];
                     state_ff <= S_LX;
                  end
                  S_LX: begin
                     lx_ff <= sw_lx[31:0];
                     sat_ff <= sat_ff | sw_lx[32];
                     state_ff <= S_LY;
                  end
                  S_LY: begin
                     ly_ff <= sw_ly[31:0];
                     sat_ff <= sat_ff | sw_ly[32];
                     state_ff <= S_OUT;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
         end else begin
            case (state_ff)
               S_IDLE: begin
                  if (req_if.valid) begin
                     zero_ff <= 1'b0;
                     emit_ff <= 1'b0;
                     if (req_if.kind) begin
                        sat_ff <= 1'b0;
                        state_ff <= S_SQX;
                     end else begin
                        pos_x_ff <= sw_lpx[31:0];
                        pos_y_ff <= sw_lpy[31:0];
                        vel_x_ff <= sw_lvx[31:0];
                        vel_y_ff <= sw_lvy[31:0];
                        sat_ff <= sw_lpx[32] | sw_lpy[32] | sw_lvx[32] | sw_lvy[32];
                        hw_ff <= 34'(req_if.load_heading);
                        spin_ff <= req_if.load_spin;
                        state_ff <= S_WRAP;
                     end
                  end
               end
               S_WRAP: begin
                  // One turn per cycle until the heading lies in (-pi, pi].
                  if (hw_ff > keo_pkg::PI_Q428) begin
                     hw_ff <= hw_ff - keo_pkg::TWO_PI_Q428;
                  end else if (hw_ff <= -keo_pkg::PI_Q428) begin
                     hw_ff <= hw_ff + keo_pkg::TWO_PI_Q428;
                  end else begin
                     head_ff <= hw_ff[31:0];
                     emit_ff <= 1'b1;
                     state_ff <= S_ANA;
                  end
               end
               S_OUT: begin
                  if (!rsp_valid_ff || rsp_if.ready) begin
                     rsp_valid_ff <= 1'b1;
                     o_pos_x_ff <= pos_x_ff;
                     o_pos_y_ff <= pos_y_ff;
                     o_vel_x_ff <= vel_x_ff;
                     o_vel_y_ff <= vel_y_ff;
                     o_head_ff <= head_ff[30:0];
                     o_ang_ff <= ang_ff;
                     o_lx_ff <= lx_ff;
                     o_ly_ff <= ly_ff;
                     o_zero_ff <= zero_ff;
                     o_sat_ff <= sat_ff;
                     state_ff <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.pos_x = o_pos_x_ff;
   assign rsp_if.pos_y = o_pos_y_ff;
   assign rsp_if.vel_x = o_vel_x_ff;
   assign rsp_if.vel_y = o_vel_y_ff;
   assign rsp_if.heading = o_head_ff;
   assign rsp_if.ang_momentum = o_ang_ff;
   assign rsp_if.lrl_x = o_lx_ff;
   assign rsp_if.lrl_y = o_ly_ff;
   assign rsp_if.zero_radius = o_zero_ff;
   assign rsp_if.saturated = o_sat_ff;

`ifndef SYNTHESIS
   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> busy_ff)
      else $error("serial unit finished without a pending operation");

   a_heading_wrapped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (head_ff <= keo_pkg::PI_Q428 && head_ff > -keo_pkg::PI_Q428))
      else $error("stored heading outside (-pi, pi]");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside the output state");

   a_no_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_OUT) |-> !unit_cmd.start)
      else $error("serial unit started outside a compute state");
`endif

endmodule
